// ===== hdl/sync_length_sum_frame_parser_macros.svh =====
// Assertion macros used by the parser RTL.
`ifndef SYNC_LENGTH_SUM_FRAME_PARSER_MACROS_SVH
`define SYNC_LENGTH_SUM_FRAME_PARSER_MACROS_SVH

// Checked on every aclk edge outside reset.
`define SLS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every aclk edge, reset included.
`define SLS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/sls_pkg.sv =====
package sls_pkg;

    // Frame format
    localparam int unsigned HEADER_BYTES = 6;
    localparam int unsigned LEN_W        = 17;
    localparam int unsigned SUM_W        = 16;
    localparam int unsigned HSUM_W       = 11;
    localparam int unsigned PSUM_W       = 32;

    localparam logic [7:0]       SYNC_FIRST  = 8'hA5;
    localparam logic [7:0]       SYNC_SECOND = 8'h5A;
    localparam logic [LEN_W-1:0] CKSUM_BYTES = LEN_W'(2);
    localparam logic [LEN_W-1:0] MIN_FRAME   = LEN_W'(8);
    localparam logic [LEN_W-1:0] MAX_LEN_RST = LEN_W'(4096);

    // Header byte positions
    localparam logic [LEN_W-1:0] IDX_LEN_LOW  = LEN_W'(3);
    localparam logic [LEN_W-1:0] IDX_LEN_HIGH = LEN_W'(4);
    localparam logic [LEN_W-1:0] IDX_HDR_LAST = LEN_W'(HEADER_BYTES - 1);

    typedef enum logic [1:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_HEADER,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        ST_GOOD      = 2'd0,
        ST_CKSUM_ERR = 2'd1,
        ST_OVERSIZE  = 2'd2,
        ST_SHORT     = 2'd3
    } status_t;

    // One byte held in the input register
    typedef struct packed {
        logic       vld;
        logic [7:0] rx_byte;
    } sls_item_t;

    typedef struct packed {
        status_t             status;
        logic [LEN_W-1:0]    frame_len;
        logic [PSUM_W-1:0]   payload_sum;
        logic [SUM_W-1:0]    rx_checksum;
    } sls_result_t;

endpackage

// ===== hdl/sls_in_stage.sv =====
module sls_in_stage
    import sls_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_byte,
    input  logic       take,
    output sls_item_t  item
);

    logic       vld_reg, vld_next;
    logic [7:0] byte_reg;
    logic       s_xfer;

    // Register is free when empty or when the core consumes it this cycle
    assign s_tready = !vld_reg || take;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        vld_next = vld_reg;
        if (s_xfer) begin
            vld_next = 1'b1;
        end else if (take) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            byte_reg <= s_byte;
        end
    end

    assign item.vld     = vld_reg;
    assign item.rx_byte = byte_reg;

endmodule

// ===== hdl/sls_core.sv =====
`include "sync_length_sum_frame_parser_macros.svh"

module sls_core
    import sls_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  sls_item_t        item,
    output logic             take,
    input  logic [LEN_W-1:0] max_frame_len,
    output logic             m_tvalid,
    input  logic             m_tready,
    output sls_result_t      m_result
);

    phase_t              phase_reg, phase_next;
    logic [LEN_W-1:0]    byte_index_reg, byte_index_next;
    logic [LEN_W-1:0]    frame_total_reg, frame_total_next;
    logic [SUM_W-1:0]    running_sum_reg, running_sum_next;
    logic [HSUM_W-1:0]   header_sum_reg, header_sum_next;
    logic [7:0]          length_low_reg, length_low_next;
    logic [7:0]          checksum_low_reg, checksum_low_next;
    logic                out_valid_reg;
    sls_result_t         out_data_reg;

    logic                emit;
    sls_result_t         result;
    logic [7:0]          b;
    logic [LEN_W-1:0]    body_end;
    logic [LEN_W-1:0]    index_inc;
    logic [SUM_W-1:0]    ck_word;

    assign b         = item.rx_byte;
    assign body_end  = frame_total_reg - CKSUM_BYTES;
    assign index_inc = byte_index_reg + LEN_W'(1);
    assign ck_word   = {b, checksum_low_reg};

    // Result of the current byte, if it closes a frame or rejects a header
    always_comb begin
        emit   = 1'b0;
        result = '0;
        case (phase_reg)
            PH_HEADER: begin
                if (byte_index_reg == IDX_HDR_LAST) begin
                    result.frame_len = frame_total_reg;
                    if (frame_total_reg > max_frame_len) begin
                        emit          = 1'b1;
                        result.status = ST_OVERSIZE;
                    end else if (frame_total_reg < MIN_FRAME) begin
                        emit          = 1'b1;
                        result.status = ST_SHORT;
                    end
                end
            end
            PH_BODY: begin
                if (byte_index_reg > body_end) begin
                    emit               = 1'b1;
                    result.status      = (ck_word == running_sum_reg) ? ST_GOOD : ST_CKSUM_ERR;
                    result.frame_len   = frame_total_reg;
                    result.rx_checksum = ck_word;
                    result.payload_sum = PSUM_W'(ck_word) - PSUM_W'(header_sum_reg);
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // A byte that yields a result waits for a free result register
    assign take = item.vld && (!emit || !out_valid_reg || m_tready);

    // Next parser state
    always_comb begin
        phase_next        = phase_reg;
        byte_index_next   = byte_index_reg;
        frame_total_next  = frame_total_reg;
        running_sum_next  = running_sum_reg;
        header_sum_next   = header_sum_reg;
        length_low_next   = length_low_reg;
        checksum_low_next = checksum_low_reg;
        case (phase_reg)
            PH_HUNT1: begin
                if (b == SYNC_FIRST) begin
                    running_sum_next = SUM_W'(b);
                    header_sum_next  = HSUM_W'(b);
                    byte_index_next  = LEN_W'(1);
                    phase_next       = PH_HUNT2;
                end
            end
            PH_HUNT2: begin
                if (b != SYNC_SECOND) begin
                    phase_next       = PH_HUNT1;
                    byte_index_next  = '0;
                    running_sum_next = '0;
                    header_sum_next  = '0;
                end else begin
                    running_sum_next = running_sum_reg + SUM_W'(b);
                    header_sum_next  = header_sum_reg + HSUM_W'(b);
                    byte_index_next  = LEN_W'(2);
                    phase_next       = PH_HEADER;
                end
            end
            PH_HEADER: begin
                running_sum_next = running_sum_reg + SUM_W'(b);
                header_sum_next  = header_sum_reg + HSUM_W'(b);
                byte_index_next  = index_inc;
                if (byte_index_reg == IDX_LEN_LOW) begin
                    length_low_next = b;
                end else if (byte_index_reg == IDX_LEN_HIGH) begin
                    frame_total_next = LEN_W'({b, length_low_reg}) + CKSUM_BYTES;
                end
                if (byte_index_reg == IDX_HDR_LAST) begin
                    if (emit) begin
                        phase_next       = PH_HUNT1;
                        byte_index_next  = '0;
                        running_sum_next = '0;
                        header_sum_next  = '0;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (byte_index_reg < body_end) begin
                    running_sum_next = running_sum_reg + SUM_W'(b);
                    byte_index_next  = index_inc;
                end else if (byte_index_reg == body_end) begin
                    checksum_low_next = b;
                    byte_index_next   = index_inc;
                end else begin
                    phase_next       = PH_HUNT1;
                    byte_index_next  = '0;
                    running_sum_next = '0;
                    header_sum_next  = '0;
                end
            end
            default: begin
                phase_next       = PH_HUNT1;
                byte_index_next  = '0;
                running_sum_next = '0;
                header_sum_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HUNT1;
            byte_index_reg   <= '0;
            frame_total_reg  <= '0;
            running_sum_reg  <= '0;
            header_sum_reg   <= '0;
            length_low_reg   <= '0;
            checksum_low_reg <= '0;
        end else if (take) begin
            phase_reg        <= phase_next;
            byte_index_reg   <= byte_index_next;
            frame_total_reg  <= frame_total_next;
            running_sum_reg  <= running_sum_next;
            header_sum_reg   <= header_sum_next;
            length_low_reg   <= length_low_next;
            checksum_low_reg <= checksum_low_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && emit) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_result = out_data_reg;

    `SLS_ASSERT(a_no_overwrite, (item.vld && emit && out_valid_reg && !m_tready) |-> !take, "result overwritten while stalled")
    `SLS_ASSERT(a_emit_loads, (take && emit) |=> out_valid_reg, "emitted result not registered")
    `SLS_ASSERT(a_body_bounds, (phase_reg == PH_BODY) |-> (frame_total_reg >= MIN_FRAME && byte_index_reg < frame_total_reg), "body index out of frame")
    `SLS_ASSERT(a_len_err_zero, (out_valid_reg && (out_data_reg.status == ST_OVERSIZE || out_data_reg.status == ST_SHORT)) |-> (out_data_reg.payload_sum == '0 && out_data_reg.rx_checksum == '0), "length error carries checksum fields")
    `SLS_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (!out_valid_reg && phase_reg == PH_HUNT1), "not idle after reset")

endmodule

// ===== hdl/sync_length_sum_frame_parser.sv =====
// Frame parser for a byte stream: hunts for the sync pair A5 5A, reads a
// four-byte rest of header whose bytes 3 and 4 hold a little-endian length L
// (frame length L + 2), sums every byte but the trailing two modulo 2^16 and
// checks that sum against the little-endian checksum word at the frame end.
// One status transaction leaves per frame or per rejected header: good,
// checksum mismatch, oversize (L + 2 above max_frame_len) or short (below 8);
// a bad second sync byte is dropped silently. The block takes one byte per
// clock while no closing byte waits on the result register; a byte passes
// an input register and then the parser logic into the result register,
// which raises m_tvalid for a byte that closes a frame or rejects a header.
// While a result waits on m_tready, bytes that produce no result keep flowing;
// only a byte that closes a frame or rejects a header waits.
// max_frame_len resets to 4096 and is written over the cfg channel, which is
// always ready. m_tuser carries the status code, m_tdata the other fields.
module sync_length_sum_frame_parser
    import sls_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // [16:0] frame_len, [48:17] payload_sum,
                                    // [64:49] rx_checksum, [71:65] zero
    output logic [1:0]  m_tuser,    // [1:0] status
    // max_frame_len register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data    // [16:0] max_frame_len
);

    logic [LEN_W-1:0] max_frame_len_reg;
    sls_item_t        item;
    logic             take;
    sls_result_t      res;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_frame_len_reg <= MAX_LEN_RST;
        end else if (cfg_valid && cfg_ready) begin
            max_frame_len_reg <= cfg_data;
        end
    end

    sls_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_byte   (s_tdata),
        .take     (take),
        .item     (item)
    );

    sls_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item          (item),
        .take          (take),
        .max_frame_len (max_frame_len_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_result      (res)
    );

    // Pack result fields
    assign m_tuser = res.status;
    assign m_tdata = {7'd0, res.rx_checksum, res.payload_sum, res.frame_len};

endmodule
